// ===== hw/rtl/sigder_pkg.sv =====
// Shared types and constants for the raw-to-DER ECDSA signature encoder.
`timescale 1ns / 1ps

package sigder_pkg;

	// Default size of one signature part (r or s) in bytes
	localparam int PART_BYTES_DEF = 32;

	localparam logic [7:0] TAG_SEQUENCE = 8'h30;
	localparam logic [7:0] TAG_INTEGER  = 8'h02;
	localparam logic [7:0] PAD_BYTE     = 8'h00;
	localparam int         HEADER_BYTES = 4;

	// Output byte source
	typedef enum logic [3:0] {
		SEL_SEQ,    // SEQUENCE tag
		SEL_BODY,   // SEQUENCE length
		SEL_INT,    // INTEGER tag
		SEL_RLEN,   // r INTEGER length
		SEL_PAD,    // 0x00 pad ahead of a part with its top bit set
		SEL_RBYTE,  // buffered r byte
		SEL_SLEN,   // s INTEGER length
		SEL_SFIRST, // held first s byte
		SEL_IN      // s byte passed through from the input
	} sel_t;

	// Controller to datapath
	typedef struct packed {
		logic in_take;  // input transaction this cycle
		logic out_load; // load the output register
		sel_t sel;
		logic idx_inc;  // step the r read index
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pos_is_r;
		logic pos_is_first_s;
		logic r_pad;
		logic s_pad;
		logic idx_end;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/sigder_dp.sv =====
// Datapath: position counter, r byte buffer, header byte selection and output register.
`timescale 1ns / 1ps

module sigder_dp import sigder_pkg::*; #(
	parameter int PART_BYTES = PART_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_data,
	output logic        out_last
);

	localparam int CW         = (2 * PART_BYTES > 1) ? $clog2(2 * PART_BYTES) : 1;
	localparam int AW         = (PART_BYTES > 1) ? $clog2(PART_BYTES) : 1;
	localparam int FINAL_POS  = 2 * PART_BYTES - 1;
	localparam int BODY_BASE  = HEADER_BYTES + 2 * PART_BYTES;
	localparam int TOTAL_BASE = BODY_BASE + 2;
	localparam bit ONE_BYTE   = (PART_BYTES == 1);

	logic [CW-1:0] pos_q;
	logic          rtop_q;
	logic          spad_q;
	logic [7:0]    sfirst_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_q;
	logic [7:0]    mem [PART_BYTES];

	logic          pos_last;
	logic [7:0]    body_len;
	logic [7:0]    rlen;
	logic [7:0]    slen;
	logic [6:0]    total_len;
	logic [7:0]    nxt_byte;
	logic          nxt_last;

	logic          out_valid_q;
	logic [15:0]   out_data_q;
	logic          out_last_q;

	assign pos_last = (pos_q == CW'(FINAL_POS));

	// Status towards the controller
	always_comb begin
		sts.pos_is_r       = (pos_q < CW'(PART_BYTES));
		sts.pos_is_first_s = (pos_q == CW'(PART_BYTES));
		sts.r_pad          = rtop_q;
		sts.s_pad          = spad_q;
		sts.idx_end        = (idx_q == AW'(PART_BYTES - 1));
		sts.out_free       = !out_valid_q || out_ready;
	end

	// Position in the raw signature, pad flags and held first s byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			rtop_q <= 1'b0;
			spad_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (cmd.in_take) begin
				pos_q <= pos_last ? '0 : pos_q + CW'(1);
				if (pos_q == '0)
					rtop_q <= in_byte[7];
				if (sts.pos_is_first_s) begin
					spad_q <= in_byte[7];
					idx_q  <= '0;
				end
			end
			if (cmd.idx_inc && !sts.idx_end)
				idx_q <= idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take && sts.pos_is_first_s)
			sfirst_q <= in_byte;
	end

	// r buffer: written while r arrives, read one entry ahead during the burst
	assign rd_addr = (cmd.idx_inc && !sts.idx_end) ? idx_q + AW'(1) : idx_q;

	always_ff @(posedge clk) begin
		if (cmd.in_take && sts.pos_is_r)
			mem[pos_q[AW-1:0]] <= in_byte;
		rd_q <= mem[rd_addr];
	end

	// Length bytes
	assign body_len  = 8'(BODY_BASE) + {7'd0, rtop_q} + {7'd0, spad_q};
	assign rlen      = 8'(PART_BYTES) + {7'd0, rtop_q};
	assign slen      = 8'(PART_BYTES) + {7'd0, spad_q};
	assign total_len = 7'(TOTAL_BASE) + {6'd0, rtop_q} + {6'd0, spad_q};

	// Output byte selection
	always_comb begin
		nxt_last = 1'b0;
		case (cmd.sel)
			SEL_SEQ:    nxt_byte = TAG_SEQUENCE;
			SEL_BODY:   nxt_byte = body_len;
			SEL_INT:    nxt_byte = TAG_INTEGER;
			SEL_RLEN:   nxt_byte = rlen;
			SEL_PAD:    nxt_byte = PAD_BYTE;
			SEL_RBYTE:  nxt_byte = rd_q;
			SEL_SLEN:   nxt_byte = slen;
			SEL_SFIRST: begin
				nxt_byte = sfirst_q;
				nxt_last = ONE_BYTE;
			end
			SEL_IN: begin
				nxt_byte = in_byte;
				nxt_last = pos_last;
			end
			default:    nxt_byte = PAD_BYTE;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {1'b0, nxt_last ? total_len : 7'd0, nxt_byte};
			out_last_q <= nxt_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

// ===== hw/rtl/sigder_ctrl.sv =====
// Controller: input handshake and sequencing of the DER header burst.
`timescale 1ns / 1ps

module sigder_ctrl import sigder_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_STREAM,
		ST_SEQ,
		ST_BODY,
		ST_RINT,
		ST_RLEN,
		ST_RPAD,
		ST_RBYTE,
		ST_SINT,
		ST_SLEN,
		ST_SPAD,
		ST_SFIRST
	} state_t;

	state_t state_q;
	state_t state_d;

	// Commands and next state
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.in_take  = 1'b0;
		cmd.out_load = 1'b0;
		cmd.sel      = SEL_IN;
		cmd.idx_inc  = 1'b0;
		unique case (state_q)
			ST_STREAM: begin
				in_ready    = sts.pos_is_r || sts.out_free;
				cmd.in_take = in_valid && in_ready;
				if (cmd.in_take && !sts.pos_is_r) begin
					if (sts.pos_is_first_s)
						state_d = ST_SEQ;
					else
						cmd.out_load = 1'b1;
				end
			end
			ST_SEQ: begin
				cmd.sel      = SEL_SEQ;
				cmd.out_load = sts.out_free;
				if (sts.out_free)
					state_d = ST_BODY;
			end
			ST_BODY: begin
				cmd.sel      = SEL_BODY;
				cmd.out_load = sts.out_free;
				if (sts.out_free)
					state_d = ST_RINT;
			end
			ST_RINT: begin
				cmd.sel      = SEL_INT;
				cmd.out_load = sts.out_free;
				if (sts.out_free)
					state_d = ST_RLEN;
			end
			ST_RLEN: begin
				cmd.sel      = SEL_RLEN;
				cmd.out_load = sts.out_free;
				if (sts.out_free)
					state_d = sts.r_pad ? ST_RPAD : ST_RBYTE;
			end
			ST_RPAD: begin
				cmd.sel      = SEL_PAD;
				cmd.out_load = sts.out_free;
				if (sts.out_free)
					state_d = ST_RBYTE;
			end
			ST_RBYTE: begin
				cmd.sel      = SEL_RBYTE;
				cmd.out_load = sts.out_free;
				cmd.idx_inc  = sts.out_free;
				if (sts.out_free && sts.idx_end)
					state_d = ST_SINT;
			end
			ST_SINT: begin
				cmd.sel      = SEL_INT;
				cmd.out_load = sts.out_free;
				if (sts.out_free)
					state_d = ST_SLEN;
			end
			ST_SLEN: begin
				cmd.sel      = SEL_SLEN;
				cmd.out_load = sts.out_free;
				if (sts.out_free)
					state_d = sts.s_pad ? ST_SPAD : ST_SFIRST;
			end
			ST_SPAD: begin
				cmd.sel      = SEL_PAD;
				cmd.out_load = sts.out_free;
				if (sts.out_free)
					state_d = ST_SFIRST;
			end
			ST_SFIRST: begin
				cmd.sel      = SEL_SFIRST;
				cmd.out_load = sts.out_free;
				if (sts.out_free)
					state_d = ST_STREAM;
			end
			default: state_d = ST_STREAM;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_STREAM;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/ecdsa_raw_to_der_signature.sv =====
// Top level of the raw-to-DER ECDSA signature encoder.
`timescale 1ns / 1ps

// Converts a raw ECDSA signature (r then s, PART_BYTES bytes each, big-endian)
// arriving one byte per transaction on the s_ channel into its DER SEQUENCE of
// two INTEGERs, one byte per transaction on the m_ channel.
// r bytes are taken one per cycle and produce no output. The first s byte
// starts a header burst of 7 + PART_BYTES output bytes, plus one for each pad
// (a 0x00 is put ahead of a part whose first byte has its top bit set); the
// burst leaves at one byte per cycle while m_tready is high, set by the single output
// register, and input is held off (s_tready low) until it is done. Each later s byte
// comes out in the cycle after it is taken, one per cycle while m_tready is high.
// Leading zero bytes are kept as they are.
// The final byte carries m_tlast and the total DER length in m_tdata[14:8];
// that field is zero on every other byte.
// Reset clears the position counter, so the next byte after reset is the first
// r byte. When m_tready is low the output register holds its byte; s_tready
// still stays high for r bytes, while s bytes wait for the register to free.
module ecdsa_raw_to_der_signature import sigder_pkg::*; #(
	parameter int PART_BYTES = PART_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] sig_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] der_byte, [14:8] der_length, [15] zero
	output logic        m_tlast
);

	cmd_t cmd;
	sts_t sts;

	sigder_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sigder_dp #(
		.PART_BYTES (PART_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_byte   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

	// A pending output byte is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output register loaded while still held");

	// The first s byte starts a burst that holds off input
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && sts.pos_is_first_s) |=> !s_tready)
		else $error("input accepted during header burst");

	// The length field is zero on every byte but the last
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[14:8] == 7'd0))
		else $error("length field set on a non-final byte");

	// Input taken only when the controller issues a take
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> cmd.in_take)
		else $error("input transaction without a take command");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the raw-to-DER ECDSA signature encoder.
`timescale 1ns / 1ps

module testbench import sigder_pkg::*; ();

	localparam int PB          = PART_BYTES_DEF;
	localparam int IDLE_LIMIT  = 2000; // cycles without any transaction
	localparam int DRAIN_WAIT  = 2 * PB + 16;

	// One expected DER byte
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [6:0] len;
	} der_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] sig_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [7:0] der_byte, [14:8] der_length, [15] zero
	logic        m_tlast;

	// Stimulus and expected DER stream
	logic [7:0]  raw_pending[$];
	der_item_t   der_expect[$];

	// Encoder state as the predictor sees it
	logic [7:0]  r_hold [PB];
	int unsigned sig_pos = 0;
	int unsigned s_pad_seen = 0;
	bit [3:0]    pad_combo_seen = '0;

	int unsigned errors = 0;
	int unsigned bytes_in = 0;
	int unsigned der_checked = 0;
	int unsigned sigs_done = 0;
	int unsigned idle_cycles = 0;

	// Driver and monitor pacing
	int unsigned in_gap = 0;
	int unsigned out_stall = 0;
	bit          in_calm = 1'b0;
	bit          out_calm = 1'b0;

	ecdsa_raw_to_der_signature uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one; none during calm stretches
	function automatic int unsigned pick_wait(input bit calm);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 30)
			$display("MISMATCH %s: got 0x%0h, want 0x%0h (DER byte %0d)",
				what, got, want, der_checked);
	endtask

	function automatic void queue_der(input logic [7:0] d, input logic l, input logic [6:0] n);
		der_expect.push_back('{data: d, last: l, len: n});
	endfunction

	// Works out the DER bytes caused by one raw signature byte
	task automatic encode_raw_byte(input logic [7:0] b);
		int unsigned rp;
		int unsigned total;
		int unsigned body;
		bit          at_end;
		at_end = (sig_pos == 2 * PB - 1);
		if (sig_pos < PB) begin
			r_hold[sig_pos] = b;
		end else begin
			rp = {31'd0, r_hold[0][7]};
			// first s byte: whole header and r INTEGER come out in one burst
			if (sig_pos == PB) begin
				s_pad_seen = {31'd0, b[7]};
				pad_combo_seen[{rp[0], b[7]}] = 1'b1;
				body = HEADER_BYTES + rp + s_pad_seen + 2 * PB;
				queue_der(TAG_SEQUENCE, 1'b0, '0);
				queue_der(body[7:0], 1'b0, '0);
				queue_der(TAG_INTEGER, 1'b0, '0);
				queue_der(8'(PB + rp), 1'b0, '0);
				if (rp != 0)
					queue_der(PAD_BYTE, 1'b0, '0);
				for (int i = 0; i < PB; i++)
					queue_der(r_hold[i], 1'b0, '0);
				queue_der(TAG_INTEGER, 1'b0, '0);
				queue_der(8'(PB + s_pad_seen), 1'b0, '0);
				if (s_pad_seen != 0)
					queue_der(PAD_BYTE, 1'b0, '0);
			end
			total = HEADER_BYTES + rp + s_pad_seen + 2 * PB + 2;
			queue_der(b, at_end, at_end ? total[6:0] : 7'd0);
		end
		sig_pos = at_end ? 0 : sig_pos + 1;
	endtask

	// Queues one full raw signature; body bytes are a fixed fill or random
	task automatic queue_signature(input logic [7:0] r0, input logic [7:0] s0,
			input logic [7:0] fill, input bit rand_fill);
		for (int i = 0; i < 2 * PB; i++) begin
			if (i == 0)
				raw_pending.push_back(r0);
			else if (i == PB)
				raw_pending.push_back(s0);
			else
				raw_pending.push_back(rand_fill ? 8'($urandom_range(0, 255)) : fill);
		end
	endtask

	// Checked on the falling edge, once the rising-edge updates have settled
	task automatic wait_drained();
		while (raw_pending.size() != 0 || s_tvalid || der_expect.size() != 0)
			@(negedge clk);
	endtask

	// Driver: presents raw bytes, predicts on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			in_gap   <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				encode_raw_byte(s_tdata);
				bytes_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (in_gap != 0) begin
					s_tvalid <= 1'b0;
					in_gap   <= in_gap - 1;
				end else if (raw_pending.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= raw_pending.pop_front();
					in_gap   <= pick_wait(in_calm);
					if ($urandom_range(0, 19) == 0)
						in_calm <= !in_calm;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure, field-by-field check of each DER byte
	always @(posedge clk or negedge arst_n) begin
		der_item_t want;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			out_stall <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (der_expect.size() == 0) begin
					report_mismatch("DER byte with none expected", int'(m_tdata), 0);
				end else begin
					want = der_expect.pop_front();
					if (m_tdata[7:0] !== want.data)
						report_mismatch("der_byte", int'(m_tdata[7:0]), int'(want.data));
					if (m_tlast !== want.last)
						report_mismatch("last", int'(m_tlast), int'(want.last));
					if (m_tdata[14:8] !== want.len)
						report_mismatch("der_length", int'(m_tdata[14:8]), int'(want.len));
					if (m_tdata[15] !== 1'b0)
						report_mismatch("spare bit", int'(m_tdata[15]), 0);
				end
				if (m_tlast === 1'b1)
					sigs_done++;
				der_checked++;
			end
			if (out_stall != 0) begin
				m_tready  <= 1'b0;
				out_stall <= out_stall - 1;
			end else begin
				m_tready  <= 1'b1;
				out_stall <= pick_wait(out_calm);
				if ($urandom_range(0, 29) == 0)
					out_calm <= !out_calm;
			end
		end
	end

	// Watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles, %0d DER bytes still due",
					IDLE_LIMIT, der_expect.size());
				$display("ecdsa_raw_to_der_signature test failed");
				$finish;
			end
		end
	end

	initial begin
		// Directed signature: r padded, s not, all-one body
		queue_signature(8'h80, 8'h00, 8'hFF, 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// hold the sender back until the directed part has fully drained
		wait_drained();

		// Second signature: s padded, r not, random body
		queue_signature(8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)),
			8'h00, 1'b1);

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Run covered %0d signatures, one padded on r and one on s: %0d raw bytes in,",
			sigs_done, bytes_in);
		$display("%0d DER bytes checked, %0d of 4 r/s pad combinations exercised.",
			der_checked, $countones(pad_combo_seen));
		if (errors == 0 && der_expect.size() == 0)
			$display("ecdsa_raw_to_der_signature test passed");
		else
			$display("ecdsa_raw_to_der_signature test failed");
		$finish;
	end

endmodule
